// ----- rtl/ybd_pkg.sv -----
// ybd_pkg: shared types, constants and the exp table for the grid-cell box decoder
// depends on nothing; used by every module of the block
package ybd_pkg;

  localparam int MAX_CLASSES     = 128;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_IDX_STEP    = 65536 / EXP_TABLE_DEPTH;
  localparam int EXP_W           = 36;
  localparam int NC_CAP          = (MAX_CLASSES < 251) ? MAX_CLASSES : 251;

  // shared multiplier operand and result widths
  localparam int MUL_A_W = 46;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = 58;

  // configuration register indexes
  localparam logic [1:0] REG_STRIDE      = 2'd0;
  localparam logic [1:0] REG_NUM_CLASSES = 2'd1;
  localparam logic [1:0] REG_ANCHOR_FREE = 2'd2;
  localparam logic [1:0] REG_CONF_THR    = 2'd3;

  // multiply steps of one cell
  localparam logic [2:0] OP_PROD = 3'd0;
  localparam logic [2:0] OP_CX   = 3'd1;
  localparam logic [2:0] OP_CY   = 3'd2;
  localparam logic [2:0] OP_WA   = 3'd3;
  localparam logic [2:0] OP_WB   = 3'd4;
  localparam logic [2:0] OP_HA   = 3'd5;
  localparam logic [2:0] OP_HB   = 3'd6;

  // output rounding steps
  localparam logic [1:0] EDGE_LEFT = 2'd0;
  localparam logic [1:0] EDGE_TOP  = 2'd1;
  localparam logic [1:0] EDGE_W    = 2'd2;
  localparam logic [1:0] EDGE_H    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SAVE,
    ST_DRAIN,
    ST_EDGE
  } state_t;

  // what the element accumulator holds for one cell
  typedef struct packed {
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic signed [15:0] box_w;
    logic signed [15:0] box_h;
    logic signed [15:0] conf;
    logic signed [15:0] prob;
    logic [6:0]         cls;
  } cell_t;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // exp(f / 2^30) in q.24, truncated series
  function automatic logic [63:0] exp_frac_q24(logic [63:0] f);
    logic [63:0] s;
    logic [63:0] t;
    s = 64'd1 << 30;
    t = s;
    t = ((t * f) >> 30) / 64'd1;  s = s + t;
    t = ((t * f) >> 30) / 64'd2;  s = s + t;
    t = ((t * f) >> 30) / 64'd3;  s = s + t;
    t = ((t * f) >> 30) / 64'd4;  s = s + t;
    t = ((t * f) >> 30) / 64'd5;  s = s + t;
    t = ((t * f) >> 30) / 64'd6;  s = s + t;
    t = ((t * f) >> 30) / 64'd7;  s = s + t;
    t = ((t * f) >> 30) / 64'd8;  s = s + t;
    t = ((t * f) >> 30) / 64'd9;  s = s + t;
    t = ((t * f) >> 30) / 64'd10; s = s + t;
    t = ((t * f) >> 30) / 64'd11; s = s + t;
    t = ((t * f) >> 30) / 64'd12; s = s + t;
    t = ((t * f) >> 30) / 64'd13; s = s + t;
    t = ((t * f) >> 30) / 64'd14; s = s + t;
    return (s + 64'd32) >> 6;
  endfunction

  // e in q.24 and half of it
  localparam logic [63:0] EXP_ONE      = exp_frac_q24(64'd1 << 30);
  localparam logic [63:0] EXP_ONE_HALF = EXP_ONE >> 1;

  function automatic logic [EXP_W-1:0] exp_entry(int i);
    int          xi;
    int          n;
    logic [63:0] u;
    logic [63:0] v;
    xi = i * EXP_IDX_STEP - 32768;
    u  = 64'(xi + 32768);
    n  = int'(u >> 12) - 8;
    v  = exp_frac_q24((u & 64'd4095) << 18);
    if (n >= 0) begin
      for (int j = 0; j < n; j++) v = (v * EXP_ONE + (64'd1 << 23)) >> 24;
    end else begin
      for (int j = 0; j < -n; j++) v = ((v << 24) + EXP_ONE_HALF) / EXP_ONE;
    end
    return EXP_W'(v);
  endfunction

  function automatic exp_tab_t build_exp_table();
    exp_tab_t tab;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) tab[i] = exp_entry(i);
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

// ----- rtl/ybd_elem_acc.sv -----
// ybd_elem_acc: per-cell element counter, box/confidence store and best-class search
// depends on ybd_pkg
module ybd_elem_acc import ybd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc_en,
  input  logic signed [15:0] elem_value,
  input  logic [7:0]         num_classes,
  output logic               cell_end,
  output cell_t              cell_data
);

  logic [7:0] elem_count_r;
  logic [7:0] nc;
  logic [7:0] last_pos;
  cell_t      cell_r;

  always_comb begin
    if (num_classes == 8'd0) begin
      nc = 8'd1;
    end else if (num_classes > 8'(NC_CAP)) begin
      nc = 8'(NC_CAP);
    end else begin
      nc = num_classes;
    end
    last_pos = nc + 8'd4;
    cell_end = !(elem_count_r < last_pos);
  end

  assign cell_data = cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_count_r <= '0;
      cell_r       <= '0;
    end else if (acc_en) begin
      case (elem_count_r)
        8'd0: cell_r.box_x <= elem_value;
        8'd1: cell_r.box_y <= elem_value;
        8'd2: cell_r.box_w <= elem_value;
        8'd3: cell_r.box_h <= elem_value;
        8'd4: cell_r.conf  <= elem_value;
        8'd5: begin
          cell_r.prob <= elem_value;
          cell_r.cls  <= '0;
        end
        default: begin
          if (elem_count_r <= last_pos && elem_value > cell_r.prob) begin
            cell_r.prob <= elem_value;
            cell_r.cls  <= 7'(elem_count_r - 8'd5);
          end
        end
      endcase
      elem_count_r <= cell_end ? 8'd0 : elem_count_r + 8'd1;
    end
  end

endmodule

// ----- rtl/ybd_mul.sv -----
// ybd_mul: the shared signed multiplier, operand registers then product register
// depends on ybd_pkg
module ybd_mul import ybd_pkg::*; (
  input  logic                      clk,
  input  logic                      ld_en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  logic signed [MUL_A_W-1:0]         a_r;
  logic signed [MUL_B_W-1:0]         b_r;
  logic signed [MUL_A_W+MUL_B_W-1:0] full;
  logic signed [MUL_P_W-1:0]         p_r;

  assign full = a_r * b_r;
  assign p    = p_r;

  always_ff @(posedge clk) begin
    if (ld_en) begin
      a_r <= a;
      b_r <= b;
    end
    p_r <= full[MUL_P_W-1:0];
  end

endmodule

// ----- rtl/yolo_grid_cell_box_decode_core.sv -----
// yolo_grid_cell_box_decode_core: top level of the grid-cell box decoder
// depends on ybd_pkg, ybd_elem_acc and ybd_mul
//
// head values enter one word per cycle while in_stall is low, cell by cell: x, y, w, h,
// confidence, then one probability per class. every word except the last of a cell is
// taken at once. the last word starts the box math, which runs seven multiplies through
// one shared multiplier (each an operand load, a multiply and a store) and then rounding
// and saturation, one box field a cycle, so the last word of a cell holds the input off
// until the box math ends, plus any wait for the previous result word to be taken.
// in_stall is high while the box math runs. at most one result word per cell, emitted
// only when confidence >= threshold and the limit score is above it; a finished result
// waits in the output register while the next cell streams in. configuration must be
// written only while the block is idle; the block itself does not enforce it.
module yolo_grid_cell_box_decode_core import ybd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_wdata,
  // head values
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_elem_value,
  input  logic [9:0]         in_cell_col,
  input  logic [9:0]         in_cell_row,
  input  logic [11:0]        in_anchor_w,
  input  logic [11:0]        in_anchor_h,
  // boxes
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_box_left,
  output logic signed [23:0] out_box_top,
  output logic signed [23:0] out_box_width,
  output logic signed [23:0] out_box_height,
  output logic signed [15:0] out_det_score,
  output logic [6:0]         out_class_id
);

  // configuration registers
  logic [7:0]  stride_r;
  logic [7:0]  num_classes_r;
  logic        anchor_free_r;
  logic [12:0] conf_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r      <= 8'd8;
      num_classes_r <= 8'd80;
      anchor_free_r <= 1'b0;
      conf_thr_r    <= 13'd2048;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STRIDE:      stride_r      <= cfg_wdata[7:0];
        REG_NUM_CLASSES: num_classes_r <= cfg_wdata[7:0];
        REG_ANCHOR_FREE: anchor_free_r <= cfg_wdata[0];
        REG_CONF_THR:    conf_thr_r    <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // sequencer
  state_t     state_r, state_nxt;
  logic [2:0] op_r;
  logic [1:0] edge_r;

  logic  in_acc;
  logic  cell_end;
  cell_t cell_data;

  // control from the output decode
  logic acc_en;
  logic mul_ld;
  logic save_en;
  logic edge_en;

  assign in_acc = in_valid && !in_stall;

  ybd_elem_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_en      (acc_en),
    .elem_value  (in_elem_value),
    .num_classes (num_classes_r),
    .cell_end    (cell_end),
    .cell_data   (cell_data)
  );

  // geometry comes from the last word of a cell
  logic [9:0]  col_r;
  logic [9:0]  row_r;
  logic [11:0] aw_r;
  logic [11:0] ah_r;

  always_ff @(posedge clk) begin
    if (in_acc && cell_end) begin
      col_r <= in_cell_col;
      row_r <= in_cell_row;
      aw_r  <= in_anchor_w;
      ah_r  <= in_anchor_h;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && cell_end) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SAVE;
      ST_SAVE:  state_nxt = (op_r == OP_HB) ? ST_DRAIN : ST_LOAD;
      ST_DRAIN: if (!out_valid) state_nxt = ST_EDGE;
      ST_EDGE:  if (edge_r == EDGE_H) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    acc_en   = 1'b0;
    mul_ld   = 1'b0;
    save_en  = 1'b0;
    edge_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        acc_en   = in_valid;
      end
      ST_LOAD:  mul_ld  = 1'b1;
      ST_MUL:   ;
      ST_SAVE:  save_en = 1'b1;
      ST_DRAIN: ;
      ST_EDGE:  edge_en = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_PROD;
      edge_r  <= EDGE_LEFT;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        op_r   <= OP_PROD;
        edge_r <= EDGE_LEFT;
      end
      if (save_en && op_r != OP_HB) op_r <= op_r + 3'd1;
      if (edge_en) edge_r <= edge_r + 2'd1;
    end
  end

  // product store, one entry per multiply step
  logic signed [MUL_P_W-1:0] res_r [7];
  logic signed [MUL_P_W-1:0] mul_p;

  always_ff @(posedge clk) begin
    if (save_en) res_r[op_r] <= mul_p;
  end

  // operand selection for the shared multiplier
  logic                       is_h;
  logic signed [24:0]         cxp;
  logic signed [24:0]         cyp;
  logic signed [16:0]         w2;
  logic signed [16:0]         h2;
  logic signed [15:0]         exp_arg;
  logic [EXP_IDX_W-1:0]       exp_idx;
  logic [EXP_W-1:0]           exp_val;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_B_W-1:0]  st_b;

  always_comb begin
    // height steps of the size math
    is_h = (op_r == OP_HA) || (op_r == OP_HB);
    if (anchor_free_r) begin
      // centre (x + col) in q.12
      cxp = 25'(cell_data.box_x) + 25'({col_r, 12'b0});
      cyp = 25'(cell_data.box_y) + 25'({row_r, 12'b0});
    end else begin
      // centre (2x - 0.5 + col) in q.12
      cxp = 25'(cell_data.box_x) * 25'sd2 - 25'sd2048 + 25'({col_r, 12'b0});
      cyp = 25'(cell_data.box_y) * 25'sd2 - 25'sd2048 + 25'({row_r, 12'b0});
    end
    w2      = 17'(cell_data.box_w) * 17'sd2;
    h2      = 17'(cell_data.box_h) * 17'sd2;
    // table index is the top bits of the value offset to unsigned
    exp_arg = is_h ? cell_data.box_h : cell_data.box_w;
    exp_idx = exp_arg[15 -: EXP_IDX_W] ^ {1'b1, {(EXP_IDX_W-1){1'b0}}};
    exp_val = EXP_TABLE[exp_idx];
    st_b    = MUL_B_W'({1'b0, stride_r});

    case (op_r)
      OP_PROD: begin
        mul_a = MUL_A_W'(cell_data.conf);
        mul_b = MUL_B_W'(cell_data.prob);
      end
      OP_CX: begin
        mul_a = MUL_A_W'(cxp);
        mul_b = st_b;
      end
      OP_CY: begin
        mul_a = MUL_A_W'(cyp);
        mul_b = st_b;
      end
      OP_WA, OP_HA: begin
        if (anchor_free_r) begin
          // stride * anchor first, exp factor next
          mul_a = MUL_A_W'({1'b0, is_h ? ah_r : aw_r});
          mul_b = st_b;
        end else begin
          // (2w)^2
          mul_a = MUL_A_W'(is_h ? h2 : w2);
          mul_b = MUL_B_W'(is_h ? h2 : w2);
        end
      end
      default: begin
        if (anchor_free_r) begin
          mul_a = MUL_A_W'({1'b0, exp_val});
          mul_b = MUL_B_W'(is_h ? res_r[OP_HA][MUL_B_W-1:0] : res_r[OP_WA][MUL_B_W-1:0]);
        end else begin
          mul_a = MUL_A_W'(is_h ? res_r[OP_HA] : res_r[OP_WA]);
          mul_b = MUL_B_W'({1'b0, is_h ? ah_r : aw_r});
        end
      end
    endcase
  end

  ybd_mul u_mul (
    .clk   (clk),
    .ld_en (mul_ld),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p)
  );

  // shared round-half-up and saturate unit for the box fields
  logic signed [59:0] edge_v;
  logic signed [59:0] edge_rnd;
  logic signed [23:0] edge_sat;

  always_comb begin
    case (edge_r)
      EDGE_LEFT: edge_v = (60'(res_r[OP_CX]) <<< 13) - 60'(res_r[OP_WB]);
      EDGE_TOP:  edge_v = (60'(res_r[OP_CY]) <<< 13) - 60'(res_r[OP_HB]);
      EDGE_W:    edge_v = 60'(res_r[OP_WB]);
      default:   edge_v = 60'(res_r[OP_HB]);
    endcase
    // edges are q.25, sizes q.24
    if (edge_r[1]) begin
      edge_rnd = (edge_v + 60'sd32768) >>> 16;
    end else begin
      edge_rnd = (edge_v + 60'sd65536) >>> 17;
    end
    if (edge_rnd > 60'sd8388607) begin
      edge_sat = 24'sh7FFFFF;
    end else if (edge_rnd < -60'sd8388608) begin
      edge_sat = 24'sh800000;
    end else begin
      edge_sat = edge_rnd[23:0];
    end
  end

  // score rounding and the emit decision
  logic signed [31:0] prod;
  logic signed [31:0] score_rnd;
  logic signed [15:0] score_sat;
  logic               conf_ok;
  logic               lim_ok;
  logic               pass;

  always_comb begin
    prod      = res_r[OP_PROD][31:0];
    score_rnd = (prod + 32'sd2048) >>> 12;
    if (score_rnd > 32'sd32767) begin
      score_sat = 16'sh7FFF;
    end else if (score_rnd < -32'sd32768) begin
      score_sat = 16'sh8000;
    end else begin
      score_sat = score_rnd[15:0];
    end
    conf_ok = 17'(cell_data.conf) >= $signed({4'b0, conf_thr_r});
    if (anchor_free_r) begin
      lim_ok = 17'(cell_data.prob) > $signed({4'b0, conf_thr_r});
    end else begin
      lim_ok = prod > $signed({7'b0, conf_thr_r, 12'b0});
    end
    pass = conf_ok && lim_ok;
  end

  // result register
  logic               out_valid_r;
  logic signed [23:0] box_left_r;
  logic signed [23:0] box_top_r;
  logic signed [23:0] box_width_r;
  logic signed [23:0] box_height_r;
  logic signed [15:0] det_score_r;
  logic [6:0]         class_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (edge_en && edge_r == EDGE_H) begin
      out_valid_r <= pass;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_en) begin
      case (edge_r)
        EDGE_LEFT: box_left_r  <= edge_sat;
        EDGE_TOP:  box_top_r   <= edge_sat;
        EDGE_W:    box_width_r <= edge_sat;
        default: begin
          box_height_r <= edge_sat;
          det_score_r  <= score_sat;
          class_id_r   <= cell_data.cls;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_box_left   = box_left_r;
  assign out_box_top    = box_top_r;
  assign out_box_width  = box_width_r;
  assign out_box_height = box_height_r;
  assign out_det_score  = det_score_r;
  assign out_class_id   = class_id_r;

endmodule

// ----- tb/sv/box_decode_checker.sv -----
// box_decode_checker: predicts decoded boxes from accepted head words and compares
// every result word with the oldest prediction; depends on ybd_pkg
`timescale 1ns / 1ps

module box_decode_checker import ybd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_elem_value,
  input  logic [9:0]         in_cell_col,
  input  logic [9:0]         in_cell_row,
  input  logic [11:0]        in_anchor_w,
  input  logic [11:0]        in_anchor_h,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] out_box_left,
  input  logic signed [23:0] out_box_top,
  input  logic signed [23:0] out_box_width,
  input  logic signed [23:0] out_box_height,
  input  logic signed [15:0] out_det_score,
  input  logic [6:0]         out_class_id,
  output int                 fail_count,
  output int                 boxes_pending
);

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic signed [23:0] width;
    logic signed [23:0] height;
    logic signed [15:0] score;
    logic [6:0]         cls;
  } box_t;

  box_t box_q[$];

  logic [7:0]  stride_r;
  logic [7:0]  ncls_r;
  logic        afree_r;
  logic [12:0] thr_r;
  int          pos;
  longint      held[4];
  longint      conf_h;
  longint      best_p;
  int          best_c;

  assign boxes_pending = box_q.size();

  // exp of a q4.12 value, q.24, by series then whole powers of e
  function automatic longint unsigned frac_exp(longint unsigned f);
    longint unsigned s;
    longint unsigned t;
    s = 64'd1 << 30;
    t = s;
    for (int k = 1; k <= 14; k++) begin
      t = ((t * f) >> 30) / k;
      s += t;
    end
    return (s + 32) >> 6;
  endfunction

  function automatic longint unsigned table_exp(longint w);
    longint unsigned idx;
    longint unsigned u;
    longint unsigned v;
    longint unsigned e1;
    int              n;
    idx = ((w + 32768) * EXP_TABLE_DEPTH) >> 16;
    u   = (idx * 65536) / EXP_TABLE_DEPTH;
    n   = int'(u >> 12) - 8;
    v   = frac_exp((u & 4095) << 18);
    e1  = frac_exp(64'd1 << 30);
    if (n >= 0) begin
      for (int i = 0; i < n; i++) v = (v * e1 + (64'd1 << 23)) >> 24;
    end else begin
      for (int i = 0; i < -n; i++) v = ((v << 24) + e1 / 2) / e1;
    end
    return v;
  endfunction

  // round half up by s bits (arithmetic shift floors), then saturate to w bits
  function automatic longint round_sat(longint v, int s, int w);
    longint r;
    longint hi;
    r  = (v + (64'sd1 <<< (s - 1))) >>> s;
    hi = (64'sd1 <<< (w - 1)) - 1;
    return r > hi ? hi : (r < -hi - 1 ? -hi - 1 : r);
  endfunction

  task automatic decode_word(longint v, longint col, longint row, longint aw, longint ah);
    int     nc;
    int     last;
    longint prod;
    longint st;
    longint thr;
    longint cx;
    longint cy;
    longint bw;
    longint bh;
    longint w2;
    longint h2;
    bit     ok;
    box_t   b;
    nc = int'(ncls_r);
    if (nc == 0) nc = 1;
    if (nc > NC_CAP) nc = NC_CAP;
    last = 4 + nc;
    if (pos < 4) held[pos] = v;
    else if (pos == 4) conf_h = v;
    else if (pos == 5) begin
      best_p = v;
      best_c = 0;
    end else if (pos <= last && v > best_p) begin
      best_p = v;
      best_c = (pos - 5) & 127;
    end
    if (pos < last) begin
      pos++;
      return;
    end
    pos  = 0;
    thr  = longint'(thr_r);
    st   = longint'(stride_r);
    prod = conf_h * best_p;
    ok   = conf_h >= thr && (afree_r ? best_p > thr : prod > thr * 4096);
    if (!ok) return;
    if (afree_r) begin
      cx = (held[0] + col * 4096) * st;
      cy = (held[1] + row * 4096) * st;
      bw = longint'(table_exp(held[2])) * st * aw;
      bh = longint'(table_exp(held[3])) * st * ah;
    end else begin
      w2 = 2 * held[2];
      h2 = 2 * held[3];
      cx = (2 * held[0] - 2048 + col * 4096) * st;
      cy = (2 * held[1] - 2048 + row * 4096) * st;
      bw = w2 * w2 * aw;
      bh = h2 * h2 * ah;
    end
    b.left   = 24'(round_sat(cx * 8192 - bw, 17, 24));
    b.top    = 24'(round_sat(cy * 8192 - bh, 17, 24));
    b.width  = 24'(round_sat(bw, 16, 24));
    b.height = 24'(round_sat(bh, 16, 24));
    b.score  = 16'(round_sat(prod, 12, 16));
    b.cls    = best_c[6:0];
    box_q = {box_q, b};
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    box_t b;
    if (!rst_n) begin
      stride_r = 8;
      ncls_r   = 80;
      afree_r  = 0;
      thr_r    = 2048;
      pos      = 0;
      held     = '{0, 0, 0, 0};
      conf_h   = 0;
      best_p   = 0;
      best_c   = 0;
      box_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_STRIDE:      stride_r = cfg_wdata[7:0];
          REG_NUM_CLASSES: ncls_r = cfg_wdata[7:0];
          REG_ANCHOR_FREE: afree_r = cfg_wdata[0];
          REG_CONF_THR:    thr_r = cfg_wdata;
        endcase
      end
      if (in_valid && !in_stall)
        decode_word(in_elem_value, in_cell_col, in_cell_row, in_anchor_w, in_anchor_h);
      if (out_valid && !out_stall) begin
        if (box_q.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count++;
        end else begin
          b = box_q.pop_front();
          check_field("box_left", b.left, out_box_left);
          check_field("box_top", b.top, out_box_top);
          check_field("box_width", b.width, out_box_width);
          check_field("box_height", b.height, out_box_height);
          check_field("det_score", b.score, out_det_score);
          check_field("class_id", b.cls, out_class_id);
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: stimulus and verdict for the grid-cell box decoder
// depends on ybd_pkg, yolo_grid_cell_box_decode_core and box_decode_checker
`timescale 1ns / 1ps

module tb_top import ybd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [12:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_elem_value;
  logic [9:0]         in_cell_col;
  logic [9:0]         in_cell_row;
  logic [11:0]        in_anchor_w;
  logic [11:0]        in_anchor_h;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] out_box_left;
  logic signed [23:0] out_box_top;
  logic signed [23:0] out_box_width;
  logic signed [23:0] out_box_height;
  logic signed [15:0] out_det_score;
  logic [6:0]         out_class_id;
  int                 fail_count;
  int                 boxes_pending;

  // idling knobs: percent of cycles each side idles; zero gives a stretch at full rate
  int  src_idle_pct;
  int  snk_stall_pct;
  int  quiet_cycles;
  int  words_sent;
  int  cur_ncls;

  yolo_grid_cell_box_decode_core uut (.*);

  box_decode_checker chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver side: random stall, independent of out_valid
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  // watchdog: counts cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_NUM_CLASSES) cur_ncls = val[7:0];
  endtask

  // wait for every predicted box, then let any box math with no result finish
  task automatic settle();
    while (boxes_pending != 0 || in_valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one head word; valid is held until accepted, random idle cycles before it
  task automatic send_word(logic signed [15:0] v, logic [9:0] col, logic [9:0] row,
                           logic [11:0] aw, logic [11:0] ah);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_elem_value <= v;
    in_cell_col   <= col;
    in_cell_row   <= row;
    in_anchor_w   <= aw;
    in_anchor_h   <= ah;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random head value: mostly plausible q4.12 numbers, some raw extremes
  function automatic logic signed [15:0] rand_val(int hi);
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(hi + 2048) - 2048);
    endcase
  endfunction

  // one whole cell; hot gives the cell a high confidence and some high class scores
  task automatic send_cell(bit hot);
    int          n;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [11:0] aw;
    logic [11:0] ah;
    n   = cur_ncls == 0 ? 1 : (cur_ncls > NC_CAP ? NC_CAP : cur_ncls);
    col = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(40));
    row = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(40));
    aw  = 12'($urandom);
    ah  = 12'($urandom_range(1) ? $urandom : $urandom_range(200));
    for (int i = 0; i < 4; i++) send_word(rand_val(8192), 10'($urandom), 10'($urandom),
                                          12'($urandom), 12'($urandom));
    send_word(hot ? 16'($urandom_range(7000, 2500)) : rand_val(4096), 0, 0, 0, 0);
    for (int i = 0; i < n; i++)
      send_word(hot && $urandom_range(3) == 0 ? 16'($urandom_range(8000, 3000))
                : rand_val(4096),
                col, row, aw, ah);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_STRIDE;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_elem_value = '0;
    in_cell_col   = '0;
    in_cell_row   = '0;
    in_anchor_w   = '0;
    in_anchor_h   = '0;
    out_stall     = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    words_sent    = 0;
    cur_ncls      = 80;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: three classes, anchor mode, extremes of every field
    cfg_write(REG_NUM_CLASSES, 13'd3);
    cfg_write(REG_STRIDE, 13'd128);
    cfg_write(REG_CONF_THR, 13'd0);
    // saturating box, tie on the best class (first wins), far corner cell
    send_word(16'sh7fff, 0, 0, 0, 0);
    send_word(16'sh8000, 0, 0, 0, 0);
    send_word(16'sh7fff, 0, 0, 0, 0);
    send_word(16'sh8000, 0, 0, 0, 0);
    send_word(16'sh1000, 0, 0, 0, 0);
    send_word(16'sh0800, 0, 0, 0, 0);
    send_word(16'sh0800, 0, 0, 0, 0);
    send_word(16'sh0400, 10'h3ff, 10'h3ff, 12'hfff, 12'hfff);
    // zero confidence so no result, class two wins, zero box values
    send_word(16'sh0, 0, 0, 0, 0);
    send_word(16'sh0, 0, 0, 0, 0);
    send_word(16'sh0, 0, 0, 0, 0);
    send_word(16'sh0, 0, 0, 0, 0);
    send_word(16'sh0, 0, 0, 0, 0);
    send_word(16'sh8000, 0, 0, 0, 0);
    send_word(16'shc000, 0, 0, 0, 0);
    send_word(16'sh0001, 10'h155, 10'h2aa, 12'h555, 12'haaa);
    drop_valid();
    settle();
    // anchor-free mode, stride zero, threshold at its maximum and then at 4096
    cfg_write(REG_ANCHOR_FREE, 13'd1);
    cfg_write(REG_STRIDE, 13'd0);
    cfg_write(REG_CONF_THR, 13'h1fff);
    send_cell(1'b1);
    drop_valid();
    settle();
    cfg_write(REG_CONF_THR, 13'd4096);
    cfg_write(REG_STRIDE, 13'd1);
    send_cell(1'b1);
    drop_valid();
    settle();
    // class count of zero acts as one; above the cap acts as the cap
    cfg_write(REG_NUM_CLASSES, 13'd0);
    cfg_write(REG_CONF_THR, 13'd100);
    send_cell(1'b1);
    drop_valid();
    settle();
    cfg_write(REG_NUM_CLASSES, 13'd255);
    send_cell(1'b1);
    drop_valid();
    settle();
    // count shrunk mid-cell: current word becomes the last
    cfg_write(REG_NUM_CLASSES, 13'd6);
    for (int i = 0; i < 8; i++) send_word(16'($urandom_range(5000, 1000)), 1, 2, 3, 4);
    drop_valid();
    cfg_write(REG_NUM_CLASSES, 13'd2);
    send_word(16'sh0fff, 10'd7, 10'd9, 12'd50, 12'd60);
    drop_valid();
    settle();

    // random phases over several settings; a full-rate stretch in the middle
    for (int ph = 0; ph < 12; ph++) begin
      cfg_write(REG_STRIDE, ph == 0 ? 13'd128 : 13'($urandom_range(1, 64)));
      cfg_write(REG_NUM_CLASSES, ph == 1 ? 13'd128 : 13'($urandom_range(1, 12)));
      cfg_write(REG_ANCHOR_FREE, 13'(ph % 2));
      cfg_write(REG_CONF_THR, ph == 2 ? 13'd4096 : 13'($urandom_range(0, 3000)));
      src_idle_pct  = (ph == 5) ? 0 : 33;
      snk_stall_pct = (ph == 5) ? 0 : 33;
      for (int w0 = words_sent; words_sent - w0 < 110;)
        send_cell($urandom_range(3) != 0);
      drop_valid();
      settle();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
